FILE: src/dzam_pkg.sv
// Shared types and constants for the decaying zone activity map.
// No dependencies; used by dzam_front, dzam_back and the top level.
package dzam_pkg;

  localparam int LOC_W    = 8;
  localparam int STR_W    = 25;
  localparam int CNT_W    = 11;

  // Reciprocal divide of an 8-bit location by the zone size
  localparam int RECIP_SH = 16;
  localparam int RECIP_W  = 17;
  localparam int PROD_W   = LOC_W + RECIP_W;

  localparam logic [STR_W-1:0] HIT_STEP     = 25'h0100000;
  localparam logic [STR_W-1:0] STRENGTH_CAP = 25'h1000000;

  typedef enum logic {
    CMD_HIT   = 1'b0,
    CMD_DECAY = 1'b1
  } cmd_t;

  // Classified request passed from front to back
  typedef struct packed {
    logic err;
    cmd_t cmd;
  } req_ctl_t;

endpackage

FILE: src/dzam_front.sv
// Front part: accepts requests, maps location to zone, range checks.
// Depends on dzam_pkg.
module dzam_front #(
  parameter int ZONE_SIZE = 8,
  parameter int ZONE_COLS = 32,
  parameter int ZONE_ROWS = 32,
  parameter int IDX_W     = 10
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               clearing,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [2*dzam_pkg::LOC_W-1:0]       in_tdata,
  input  logic                               in_tuser,
  output logic                               q_push,
  input  logic                               q_ready,
  output dzam_pkg::req_ctl_t                 q_ctl,
  output logic [IDX_W-1:0]                   q_idx
);

  localparam int RECIP = ((1 << dzam_pkg::RECIP_SH) + ZONE_SIZE - 1) / ZONE_SIZE;

  logic                       f_valid_r;
  dzam_pkg::req_ctl_t         f_ctl_r, f_ctl_nxt;
  logic [dzam_pkg::LOC_W-1:0] f_col_r, f_row_r, col_nxt, row_nxt;
  logic [dzam_pkg::PROD_W-1:0] px, py;
  logic [dzam_pkg::LOC_W+9:0] idx_full;
  logic                       take;

  assign in_tready = !clearing && (!f_valid_r || q_ready);
  assign take      = in_tvalid && in_tready;

  // x / ZONE_SIZE exactly, for 8-bit x and sizes up to 64
  assign px      = dzam_pkg::PROD_W'(in_tdata[dzam_pkg::LOC_W-1:0])
                 * dzam_pkg::PROD_W'(RECIP);
  assign py      = dzam_pkg::PROD_W'(in_tdata[2*dzam_pkg::LOC_W-1:dzam_pkg::LOC_W])
                 * dzam_pkg::PROD_W'(RECIP);
  assign col_nxt = px[dzam_pkg::RECIP_SH +: dzam_pkg::LOC_W];
  assign row_nxt = py[dzam_pkg::RECIP_SH +: dzam_pkg::LOC_W];

  always_comb begin
    f_ctl_nxt.cmd = dzam_pkg::cmd_t'(in_tuser);
    f_ctl_nxt.err = (f_ctl_nxt.cmd == dzam_pkg::CMD_HIT) &&
                    (({1'b0, col_nxt} >= 9'(ZONE_COLS)) ||
                     ({1'b0, row_nxt} >= 9'(ZONE_ROWS)));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else if (take) begin
      f_valid_r <= 1'b1;
    end else if (q_ready) begin
      f_valid_r <= 1'b0;
    end
    if (take) begin
      f_ctl_r <= f_ctl_nxt;
      f_col_r <= col_nxt;
      f_row_r <= row_nxt;
    end
  end

  // Linear zone index, row major
  assign idx_full = (dzam_pkg::LOC_W+10)'(f_row_r) * (dzam_pkg::LOC_W+10)'(ZONE_COLS)
                  + (dzam_pkg::LOC_W+10)'(f_col_r);
  assign q_idx    = idx_full[IDX_W-1:0];
  assign q_ctl    = f_ctl_r;
  assign q_push   = f_valid_r && q_ready;

endmodule

FILE: src/dzam_queue.sv
// Two-entry request queue between front and back.
// No package dependencies.
module dzam_queue #(
  parameter int W = 12
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         push_ready,
  input  logic         pop,
  output logic         pop_valid,
  output logic [W-1:0] pop_data
);

  logic [W-1:0] slot_r [2];
  logic         wr_ptr_r, rd_ptr_r;
  logic [1:0]   count_r;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_data   = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      if (push && !pop)      count_r <= count_r + 2'd1;
      else if (pop && !push) count_r <= count_r - 2'd1;
    end
    if (push) slot_r[wr_ptr_r] <= push_data;
  end

endmodule

FILE: src/dzam_back.sv
// Back part: zone store, clearing pass, hit read-modify-write, decay sweep, result register.
// Depends on dzam_pkg.
module dzam_back #(
  parameter int ZONE_COUNT = 1024,
  parameter int IDX_W      = 10
) (
  input  logic                         clk,
  input  logic                         rst_n,
  output logic                         clearing,
  input  logic                         q_valid,
  input  dzam_pkg::req_ctl_t           q_ctl,
  input  logic [IDX_W-1:0]             q_idx,
  output logic                         q_pop,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [dzam_pkg::STR_W-1:0]   out_strength,
  output logic [dzam_pkg::CNT_W-1:0]   out_count,
  output logic                         out_err
);

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_HIT   = 5'b00100,
    ST_DECAY = 5'b01000,
    ST_DOUT  = 5'b10000
  } state_t;

  localparam logic [IDX_W:0] PTR_END = (IDX_W+1)'(ZONE_COUNT);

  state_t                     state_r, state_nxt;
  logic [IDX_W:0]             ptr_r, ptr_nxt;
  logic [dzam_pkg::CNT_W-1:0] acc_r, acc_nxt, active_r, active_nxt;
  logic                       rd_pend_r;
  logic [IDX_W-1:0]           rd_addr_q_r;
  logic [dzam_pkg::STR_W-1:0] rdata_r;
  logic [dzam_pkg::STR_W-1:0] mem [ZONE_COUNT];

  logic                       rd_en, wr_en;
  logic [IDX_W-1:0]           rd_addr, wr_addr;
  logic [dzam_pkg::STR_W-1:0] wr_data, sat;
  logic [dzam_pkg::STR_W:0]   sum;
  logic                       out_free, load;
  logic [dzam_pkg::STR_W-1:0] ld_str;
  logic [dzam_pkg::CNT_W-1:0] ld_cnt;
  logic                       ld_err;

  logic                       out_valid_r;
  logic [dzam_pkg::STR_W-1:0] out_str_r;
  logic [dzam_pkg::CNT_W-1:0] out_cnt_r;
  logic                       out_err_r;

  assign out_free = !out_valid_r || out_ready;
  assign clearing = (state_r == ST_CLEAR);

  assign sum = {1'b0, rdata_r} + {1'b0, dzam_pkg::HIT_STEP};
  assign sat = (sum > {1'b0, dzam_pkg::STRENGTH_CAP}) ? dzam_pkg::STRENGTH_CAP
                                                      : sum[dzam_pkg::STR_W-1:0];

  always_comb begin
    state_nxt  = state_r;
    ptr_nxt    = ptr_r;
    acc_nxt    = acc_r;
    active_nxt = active_r;
    q_pop      = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = q_idx;
    wr_en      = 1'b0;
    wr_addr    = rd_addr_q_r;
    wr_data    = sat;
    load       = 1'b0;
    ld_str     = '0;
    ld_cnt     = active_r;
    ld_err     = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = ptr_r[IDX_W-1:0];
        wr_data = '0;
        ptr_nxt = ptr_r + 1'b1;
        if (ptr_r[IDX_W-1:0] == IDX_W'(ZONE_COUNT - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (q_valid) begin
          if (q_ctl.cmd == dzam_pkg::CMD_DECAY) begin
            q_pop     = 1'b1;
            ptr_nxt   = '0;
            acc_nxt   = '0;
            state_nxt = ST_DECAY;
          end else if (q_ctl.err) begin
            if (out_free) begin
              q_pop  = 1'b1;
              load   = 1'b1;
              ld_err = 1'b1;
            end
          end else begin
            q_pop     = 1'b1;
            rd_en     = 1'b1;
            state_nxt = ST_HIT;
          end
        end
      end
      ST_HIT: begin
        if (out_free) begin
          wr_en     = 1'b1;
          load      = 1'b1;
          ld_str    = sat;
          state_nxt = ST_IDLE;
        end
      end
      ST_DECAY: begin
        if (ptr_r != PTR_END) begin
          rd_en   = 1'b1;
          rd_addr = ptr_r[IDX_W-1:0];
          ptr_nxt = ptr_r + 1'b1;
        end
        if (rd_pend_r) begin
          wr_en   = 1'b1;
          wr_data = rdata_r >> 1;
          acc_nxt = acc_r + dzam_pkg::CNT_W'(|rdata_r[dzam_pkg::STR_W-1:1]);
        end
        if (ptr_r == PTR_END && !rd_pend_r) state_nxt = ST_DOUT;
      end
      ST_DOUT: begin
        if (out_free) begin
          active_nxt = acc_r;
          load       = 1'b1;
          ld_cnt     = acc_r;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      ptr_r       <= '0;
      acc_r       <= '0;
      active_r    <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      ptr_r     <= ptr_nxt;
      acc_r     <= acc_nxt;
      active_r  <= active_nxt;
      rd_pend_r <= rd_en;
      if (load)           out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
    if (load) begin
      out_str_r <= ld_str;
      out_cnt_r <= ld_cnt;
      out_err_r <= ld_err;
    end
  end

  // Zone store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) begin
      rdata_r     <= mem[rd_addr];
      rd_addr_q_r <= rd_addr;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_strength = out_str_r;
  assign out_count    = out_cnt_r;
  assign out_err      = out_err_r;

`ifndef SYNTHESIS
  a_no_read_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> (!rd_en && !q_pop))
    else $error("zone store read or request popped during clearing pass");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_err_r) |-> (out_str_r == '0))
    else $error("range error result carries a nonzero strength");

  a_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_str_r <= dzam_pkg::STRENGTH_CAP))
    else $error("reported strength above the cap");

  a_hit_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && rd_en) |=> (state_r == ST_HIT && rd_pend_r))
    else $error("hit read not followed by write-back state");
`endif

endmodule

FILE: src/decaying_zone_activity_map_unit.sv
// Top level of the decaying zone activity map: front, request queue, back.
// Depends on dzam_pkg, dzam_front, dzam_queue, dzam_back.
//
//  channel | dir | tdata (low bit up)                        | tuser
//  --------+-----+-------------------------------------------+--------------
//  in_     | in  | x_loc[7:0], y_loc[15:8]                   | cmd
//  out_    | out | zone_strength[24:0], active_count[35:25], | range_error
//          |     | zero pad [39:36]                          |
//
// Back part: a hit makes a registered read of the zone store, then a
// saturating add and write-back; an off-grid hit skips the store. A decay
// request walks the store one zone per cycle, set by the single read and
// single write port: pop, a read and a halving write-back of each zone, an
// idle check, then the result load.
// Reset: synchronous, active low; afterwards a clearing pass writes zero to
// every zone while in_tready stays low.
// Stalls: a two-entry queue parts front and back, so while a result waits the
// front keeps accepting until the queue and the front register are full.
module decaying_zone_activity_map_unit #(
  parameter int ZONE_SIZE = 8,
  parameter int ZONE_COLS = 32,
  parameter int ZONE_ROWS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // x_loc[7:0], y_loc[15:8]
  input  logic        in_tuser,   // cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // zone_strength[24:0], active_count[35:25], pad
  output logic        out_tuser   // range_error
);

  localparam int ZONE_COUNT = ZONE_COLS * ZONE_ROWS;
  localparam int IDX_W      = (ZONE_COUNT > 1) ? $clog2(ZONE_COUNT) : 1;
  localparam int CTL_W      = $bits(dzam_pkg::req_ctl_t);
  localparam int Q_W        = IDX_W + CTL_W;

  logic                       clearing;
  logic                       q_push, q_ready, q_pop, q_valid;
  dzam_pkg::req_ctl_t         f_ctl, b_ctl;
  logic [IDX_W-1:0]           f_idx, b_idx;
  logic [Q_W-1:0]             q_out;
  logic [dzam_pkg::STR_W-1:0] strength;
  logic [dzam_pkg::CNT_W-1:0] count;

  dzam_front #(
    .ZONE_SIZE (ZONE_SIZE),
    .ZONE_COLS (ZONE_COLS),
    .ZONE_ROWS (ZONE_ROWS),
    .IDX_W     (IDX_W)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .clearing  (clearing),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_push    (q_push),
    .q_ready   (q_ready),
    .q_ctl     (f_ctl),
    .q_idx     (f_idx)
  );

  // Queue entry: zone index above the request class
  dzam_queue #(
    .W (Q_W)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  ({f_idx, f_ctl}),
    .push_ready (q_ready),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_data   (q_out)
  );

  assign b_ctl = dzam_pkg::req_ctl_t'(q_out[CTL_W-1:0]);
  assign b_idx = q_out[Q_W-1:CTL_W];

  dzam_back #(
    .ZONE_COUNT (ZONE_COUNT),
    .IDX_W      (IDX_W)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .clearing     (clearing),
    .q_valid      (q_valid),
    .q_ctl        (b_ctl),
    .q_idx        (b_idx),
    .q_pop        (q_pop),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_strength (strength),
    .out_count    (count),
    .out_err      (out_tuser)
  );

  assign out_tdata = {4'b0000, count, strength};

endmodule
